// ----- sv/prl_pkg.sv -----
// shared types and constants for the per-client rate limiter
// used by prl_ctrl, prl_datapath and per_client_rate_limiter
package prl_pkg;

  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 32;
  localparam int WINDOW_W   = 16;
  localparam int LIMIT_W    = 8;
  localparam int TOTAL_W    = 8;
  localparam int VERDICT_W  = 2;
  localparam int SLOT_W     = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [VERDICT_W-1:0] VERDICT_ALLOWED = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NO_SLOT = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BLOCKED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS   = 4'd1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd60;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd30;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = 8'hFF;
  localparam logic [TOTAL_W-1:0]  TOTAL_ONE    = 8'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] client_addr;
    logic [TIME_W-1:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [SLOT_W-1:0]    slot_index;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [TIME_W-1:0]  wstart;
    logic [TOTAL_W-1:0] total;
    logic               blocked;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic out_full;
  } sts_t;

endpackage

// ----- sv/prl_ctrl.sv -----
// request sequencer for the per-client rate limiter
// depends on prl_pkg (cmd_t, sts_t)
module prl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  prl_pkg::sts_t sts,
  output prl_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!sts.out_full) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/prl_datapath.sv -----
// client table, lookup scan, window/limit update and output register
// depends on prl_pkg (types, verdict and register codes)
module prl_datapath #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  prl_pkg::cmd_t                    cmd,
  output prl_pkg::sts_t                    sts,
  input  prl_pkg::req_t                    in_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prl_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output prl_pkg::res_t                    out_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

  prl_pkg::entry_t mem [TABLE_ENTRIES];

  logic [prl_pkg::WINDOW_W-1:0] window_seconds;
  logic [prl_pkg::LIMIT_W-1:0]  max_requests;

  prl_pkg::req_t   req;
  logic [CW-1:0]   fill;
  logic [CW-1:0]   scan;
  logic            pend;
  logic [IW-1:0]   pend_idx;
  prl_pkg::entry_t rd_data;

  prl_pkg::entry_t ent;
  logic [IW-1:0]   slot;
  logic            is_new;
  logic            no_slot;

  logic            hit;
  logic            miss;
  logic            issue;

  prl_pkg::entry_t            wr_ent;
  prl_pkg::res_t              res;
  logic [prl_pkg::TIME_W-1:0] elapsed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= prl_pkg::WINDOW_RESET;
      max_requests   <= prl_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == prl_pkg::REG_WINDOW_SECONDS) begin
        window_seconds <= cfg_data;
      end else if (cfg_index == prl_pkg::REG_MAX_REQUESTS) begin
        max_requests <= cfg_data[prl_pkg::LIMIT_W-1:0];
      end
    end
  end

  // scan: entries 0 .. fill-1 are in use, read one per cycle
  assign issue = cmd.scan && (scan < fill);
  assign hit   = cmd.scan && pend && (rd_data.addr == req.client_addr);
  assign miss  = cmd.scan && !pend && (scan >= fill);

  assign sts.found    = hit || miss;
  assign sts.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[scan[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.load) begin
      pend <= 1'b0;
    end else if (cmd.scan) begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= in_data;
      scan <= '0;
    end else if (issue) begin
      scan     <= scan + 1'b1;
      pend_idx <= scan[IW-1:0];
    end
    if (hit) begin
      ent     <= rd_data;
      slot    <= pend_idx;
      is_new  <= 1'b0;
      no_slot <= 1'b0;
    end else if (miss) begin
      ent.addr    <= req.client_addr;
      ent.wstart  <= req.now_seconds;
      ent.total   <= '0;
      ent.blocked <= 1'b0;
      is_new      <= (fill < FULL);
      no_slot     <= (fill >= FULL);
      slot        <= (fill < FULL) ? fill[IW-1:0] : '0;
    end
  end

  // window and limit decision
  assign elapsed = req.now_seconds - ent.wstart;

  always_comb begin
    wr_ent         = ent;
    res.verdict    = prl_pkg::VERDICT_ALLOWED;
    res.slot_index = prl_pkg::SLOT_W'(slot);
    priority if (no_slot) begin
      res.verdict    = prl_pkg::VERDICT_NO_SLOT;
      res.slot_index = '0;
    end else if (ent.blocked) begin
      res.verdict = prl_pkg::VERDICT_BLOCKED;
    end else if (elapsed > prl_pkg::TIME_W'(window_seconds)) begin
      wr_ent.wstart = req.now_seconds;
      wr_ent.total  = prl_pkg::TOTAL_ONE;
    end else begin
      if (ent.total > max_requests) begin
        wr_ent.blocked = 1'b1;
        res.verdict    = prl_pkg::VERDICT_BLOCKED;
      end
      if (ent.total != prl_pkg::TOTAL_MAX) begin
        wr_ent.total = ent.total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !no_slot) begin
      mem[slot] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.commit && is_new) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= res;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FULL)
    else $error("table fill count beyond table size");

  a_hit_miss: assert property (@(posedge clk) disable iff (rst) !(hit && miss))
    else $error("lookup reports hit and miss together");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (fill == $past(fill) || fill == $past(fill) + 1'b1))
    else $error("fill count moved by more than one");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && !out_ready))
    else $error("result written over an untaken one");

endmodule

// ----- sv/per_client_rate_limiter.sv -----
// top level of the per-client fixed-window rate limiter
// depends on prl_pkg, prl_ctrl and prl_datapath
//
// usage: a request carries client_addr and now_seconds on in_data and is
// taken when in_valid and in_ready are both high. each request yields one
// result on out_data (verdict, slot_index), handed over on out_valid/out_ready.
// the client table holds entries 0 .. fill-1 and is read one entry per cycle
// through a single memory port; a lookup scans the entries in order and ends
// on the first entry whose address matches, or as a miss once all fill entries
// are read. the result register is loaded as the update step commits, and a
// new request is taken once the controller is back in idle, which it enters
// as the previous result is registered.
// in_ready is high only between requests. the result register lets the next
// request be taken and searched while a result waits; if out_ready stays low
// the finished request holds in its update step until the result is taken.
// reset returns both registers to their defaults and empties the table via
// the fill count; no clearing pass is needed. configuration writes on
// cfg_valid/cfg_index/cfg_data are taken every cycle, and belong between
// requests; unknown register indexes are ignored.
module per_client_rate_limiter #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  prl_pkg::req_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output prl_pkg::res_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prl_pkg::CFG_DATA_W-1:0] cfg_data
);

  prl_pkg::cmd_t cmd;
  prl_pkg::sts_t sts;

  prl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  prl_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
